// File: design/hfa_pkg.sv
// Shared types and constants for the hole fit allocator.
`default_nettype none

package hfa_pkg;

   // Fixed field widths
   localparam int REQ_W         = 16;
   localparam int IDX_W         = 4;
   localparam int CNT_W         = 5;
   localparam int MODE_W        = 2;
   localparam int ADDRESSABLE   = 16;

   // Defaults for top-level parameters
   localparam int NUM_HOLES_DEF  = 16;
   localparam int SIZE_WIDTH_DEF = 16;

   // Search policies
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Register indexes (paddr bit 2)
   localparam logic REG_FIT_MODE   = 1'b0;
   localparam logic REG_HOLE_COUNT = 1'b1;

   // Reset values of the registers
   localparam logic [MODE_W-1:0] FIT_MODE_RST   = FIT_FIRST;
   localparam logic [CNT_W-1:0]  HOLE_COUNT_RST = 5'd16;

   typedef struct packed {
      logic             op;
      logic [IDX_W-1:0] hole_index;
      logic [REQ_W-1:0] load_size;
      logic [REQ_W-1:0] request_size;
   } req_word_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] chosen_hole;
      logic [REQ_W-1:0] remaining_size;
   } rsp_word_type;

   // Control part of the search token that walks the cell chain
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] best;
   } tok_ctl_type;

   // Write strobe broadcast to the cells
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } wr_ctl_type;

endpackage

`default_nettype wire

// File: design/hfa_cell.sv
// One cell of the chain: holds one hole size and updates the passing search token.
`default_nettype none

module hfa_cell
   import hfa_pkg::*;
#(
   parameter int SizeWidth = SIZE_WIDTH_DEF,
   parameter int Index     = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [MODE_W-1:0]         mode,
   input  wire  [CNT_W-1:0]          count,
   input  wr_ctl_type                wr,
   input  wire  [SizeWidth-1:0]      wr_data,
   input  tok_ctl_type               tok_in,
   input  wire  [SizeWidth-1:0]      key_in,
   input  wire  [SizeWidth-1:0]      rem_in,
   input  wire  [REQ_W-1:0]          req_in,
   output tok_ctl_type               tok_out,
   output logic [SizeWidth-1:0]      key_out,
   output logic [SizeWidth-1:0]      rem_out,
   output logic [REQ_W-1:0]          req_out
);

   localparam int CmpW = (SizeWidth > REQ_W) ? SizeWidth : REQ_W;

   logic [SizeWidth-1:0] hole_ff;
   tok_ctl_type          tok_ff, tok_in_nx;
   logic [SizeWidth-1:0] key_ff, key_in_nx;
   logic [SizeWidth-1:0] rem_ff;
   logic [REQ_W-1:0]     req_ff;

   logic [CmpW-1:0]      hole_ext, req_ext, left_ext;
   logic [SizeWidth-1:0] left;
   logic                 active, fits, take;

   // Compare this cell's hole with the request
   assign active   = int'(count) > Index;
   assign hole_ext = CmpW'(hole_ff);
   assign req_ext  = CmpW'(req_in);
   assign fits     = active && (hole_ext >= req_ext);
   assign left_ext = hole_ext - req_ext;
   assign left     = left_ext[SizeWidth-1:0];

   // Policy decision; earlier cells win ties
   always_comb begin
      case (mode)
         FIT_BEST:  take = fits && (!tok_in.found || left < key_in);
         FIT_WORST: take = fits && (!tok_in.found || hole_ff > key_in);
         default:   take = fits && !tok_in.found;
      endcase
   end

   always_comb begin
      tok_in_nx       = tok_in;
      tok_in_nx.found = tok_in.found | take;
      tok_in_nx.best  = take ? IDX_W'(Index) : tok_in.best;
      key_in_nx       = key_in;
      if (take) begin
         key_in_nx = (mode == FIT_BEST) ? left : hole_ff;
      end
   end

   // Hole storage: loads and post-grant shrink
   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff <= '0;
      end else if (wr.en && wr.idx == IDX_W'(Index)) begin
         hole_ff <= wr_data;
      end
   end

   // Token stage toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.found <= tok_in_nx.found;
      tok_ff.best  <= tok_in_nx.best;
      key_ff       <= key_in_nx;
      rem_ff       <= take ? left : rem_in;
      req_ff       <= req_in;
   end

   assign tok_out = tok_ff;
   assign key_out = key_ff;
   assign rem_out = rem_ff;
   assign req_out = req_ff;

endmodule

`default_nettype wire

// File: design/hole_fit_allocator.sv
// Top level of the hole fit allocator: register port, cell chain, result buffering.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_word (req_word_type)
//   rsp       out        rsp_valid / rsp_stall  rsp_word (rsp_word_type)
//   csr       in/out     psel/penable, pready   paddr, pwdata, prdata
//
// A load word is written into the table when it is accepted.
// An allocate word walks the chain one cell per cycle; its result passes through the
// registers of the N = min(NumHoles, 16) cells, then the pending result register,
// then into the output register once that register is free.
// Reset clears the hole table and all valid flags and resets both registers.
// req_stall is high during a search and while its result waits for the output
// register; a stalled output therefore also holds up the next search.
`default_nettype none

module hole_fit_allocator
   import hfa_pkg::*;
#(
   parameter int NumHoles  = NUM_HOLES_DEF,
   parameter int SizeWidth = SIZE_WIDTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   // input channel
   input  wire          req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   // result channel
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_word_type rsp_word,
   // register port
   input  wire          psel,
   input  wire          penable,
   input  wire          pwrite,
   input  wire  [2:0]   paddr,
   input  wire  [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int NumCells = (NumHoles < ADDRESSABLE) ? NumHoles : ADDRESSABLE;
   localparam int ExtW     = (SizeWidth > REQ_W) ? SizeWidth : REQ_W;

   // Configuration registers
   logic [MODE_W-1:0] fit_mode_ff;
   logic [CNT_W-1:0]  hole_count_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= FIT_MODE_RST;
         hole_count_ff <= HOLE_COUNT_RST;
      end else if (csr_write) begin
         case (paddr[2])
            REG_FIT_MODE:   fit_mode_ff   <= pwdata[MODE_W-1:0];
            REG_HOLE_COUNT: hole_count_ff <= pwdata[CNT_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FIT_MODE:   prdata = 32'(fit_mode_ff);
         REG_HOLE_COUNT: prdata = 32'(hole_count_ff);
         default:        prdata = '0;
      endcase
   end

   // Input acceptance
   logic scan_ff, pend_ff;
   logic accept, alloc_accept, load_accept;

   assign req_stall    = scan_ff || pend_ff;
   assign accept       = req_valid && !req_stall;
   assign alloc_accept = accept && (req_word.op == OP_ALLOC);
   assign load_accept  = accept && (req_word.op == OP_LOAD)
                         && (int'(req_word.hole_index) < NumHoles);

   // Cell chain
   tok_ctl_type          tok_chain [0:NumCells];
   logic [SizeWidth-1:0] key_chain [0:NumCells];
   logic [SizeWidth-1:0] rem_chain [0:NumCells];
   logic [REQ_W-1:0]     req_chain [0:NumCells];
   wr_ctl_type           wr;
   logic [SizeWidth-1:0] wr_data;
   tok_ctl_type          tail;

   assign tok_chain[0].valid = alloc_accept;
   assign tok_chain[0].found = 1'b0;
   assign tok_chain[0].best  = '0;
   assign key_chain[0]       = '0;
   assign rem_chain[0]       = '0;
   assign req_chain[0]       = req_word.request_size;

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      hfa_cell #(
         .SizeWidth (SizeWidth),
         .Index     (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .mode    (fit_mode_ff),
         .count   (hole_count_ff),
         .wr      (wr),
         .wr_data (wr_data),
         .tok_in  (tok_chain[g]),
         .key_in  (key_chain[g]),
         .rem_in  (rem_chain[g]),
         .req_in  (req_chain[g]),
         .tok_out (tok_chain[g+1]),
         .key_out (key_chain[g+1]),
         .rem_out (rem_chain[g+1]),
         .req_out (req_chain[g+1])
      );
   end

   assign tail = tok_chain[NumCells];

   // Table write: a load, or the shrink of the granted hole at chain exit
   always_comb begin
      wr.en   = 1'b0;
      wr.idx  = req_word.hole_index;
      wr_data = SizeWidth'(req_word.load_size);
      if (tail.valid) begin
         wr.en   = tail.found;
         wr.idx  = tail.best;
         wr_data = rem_chain[NumCells];
      end else if (load_accept) begin
         wr.en = 1'b1;
      end
   end

   // Result formatting
   logic [ExtW-1:0] rem_ext;
   rsp_word_type    res_in;
   rsp_word_type    res_ff;
   logic            move;

   assign rem_ext = ExtW'(rem_chain[NumCells]);

   always_comb begin
      res_in = '0;
      if (tail.found) begin
         res_in.granted        = 1'b1;
         res_in.chosen_hole    = tail.best;
         res_in.remaining_size = rem_ext[REQ_W-1:0];
      end
   end

   // Search busy flag and pending result
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign move = pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (alloc_accept) begin
            scan_ff <= 1'b1;
         end else if (tail.valid) begin
            scan_ff <= 1'b0;
         end
         if (tail.valid) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
      end
      if (tail.valid) begin
         res_ff <= res_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (move) begin
         rsp_word_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// File: design/hfa_checker.sv
// Port-level checks for the hole fit allocator, bound to the top level.
`default_nettype none

module hfa_checker
   import hfa_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          req_valid,
   input wire          req_stall,
   input req_word_type req_word,
   input wire          rsp_valid,
   input wire          rsp_stall,
   input rsp_word_type rsp_word
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A refusal carries zero index and size
   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.granted) |->
         (rsp_word.chosen_hole == '0 && rsp_word.remaining_size == '0))
      else $error("refusal with nonzero fields");

   // An accepted allocate word blocks the input while it is searched
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.op == OP_ALLOC) |=> req_stall)
      else $error("input not stalled during search");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result changed");

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (.*);

`default_nettype wire

// File: tb/hole_fit_allocator_tb.sv
// Self-checking testbench for the hole fit allocator: directed and random words under all fit modes.
`timescale 1ns / 1ps

module hole_fit_allocator_tb
   import hfa_pkg::*;
();

   // Unnamed fourth mode value, expected to behave as first fit
   localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 12;
   localparam int PHASE_WORDS   = 125;

   // Table of free holes, the two registers and the grants still to come
   class hole_table_predictor;
      logic [REQ_W-1:0]  hole_size [NUM_HOLES_DEF];
      logic [MODE_W-1:0] fit_mode;
      logic [CNT_W-1:0]  hole_count;
      rsp_word_type      expected_grants [$];
      int                loads_seen;
      int                grants_seen;
      int                refusals_seen;
      int                mismatches;

      function new();
         foreach (hole_size[j]) hole_size[j] = '0;
         fit_mode      = FIT_MODE_RST;
         hole_count    = HOLE_COUNT_RST;
         loads_seen    = 0;
         grants_seen   = 0;
         refusals_seen = 0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == REG_FIT_MODE) begin
            fit_mode = value[MODE_W-1:0];
         end else begin
            hole_count = value[CNT_W-1:0];
         end
      endfunction

      // Apply one accepted request word; allocations queue their grant
      function void predict_word(req_word_type w);
         int               active;
         int               j;
         int               pick;
         bit               found;
         logic [REQ_W-1:0] key;
         logic [REQ_W-1:0] left;
         rsp_word_type     r;
         if (w.op == OP_LOAD) begin
            if (w.hole_index < NUM_HOLES_DEF) hole_size[w.hole_index] = w.load_size;
            loads_seen++;
            return;
         end
         active = hole_count;
         if (active > NUM_HOLES_DEF) active = NUM_HOLES_DEF;
         if (active > ADDRESSABLE) active = ADDRESSABLE;
         found = 1'b0;
         pick  = 0;
         key   = '0;
         // Scan active holes; strict compares keep ties on the lowest index
         for (j = 0; j < active; j++) begin
            if (hole_size[j] >= w.request_size) begin
               left = hole_size[j] - w.request_size;
               case (fit_mode)
                  FIT_BEST: begin
                     if (!found || left < key) begin
                        found = 1'b1;
                        key   = left;
                        pick  = j;
                     end
                  end
                  FIT_WORST: begin
                     if (!found || hole_size[j] > key) begin
                        found = 1'b1;
                        key   = hole_size[j];
                        pick  = j;
                     end
                  end
                  default: begin
                     if (!found) begin
                        found = 1'b1;
                        pick  = j;
                     end
                  end
               endcase
            end
         end
         r = '0;
         if (found) begin
            hole_size[pick]  = hole_size[pick] - w.request_size;
            r.granted        = 1'b1;
            r.chosen_hole    = pick[IDX_W-1:0];
            r.remaining_size = hole_size[pick];
            grants_seen++;
         end else begin
            refusals_seen++;
         end
         expected_grants.push_back(r);
      endfunction

      // Compare one accepted result word with the oldest pending grant
      function void compare_grant(rsp_word_type got);
         rsp_word_type want;
         if (expected_grants.size() == 0) begin
            $error("unexpected result word: granted=%0d chosen_hole=%0d remaining_size=%0d",
                   got.granted, got.chosen_hole, got.remaining_size);
            mismatches++;
            return;
         end
         want = expected_grants.pop_front();
         if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            mismatches++;
         end
         if (got.chosen_hole !== want.chosen_hole) begin
            $error("chosen_hole: expected %0d, actual %0d", want.chosen_hole, got.chosen_hole);
            mismatches++;
         end
         if (got.remaining_size !== want.remaining_size) begin
            $error("remaining_size: expected %0d, actual %0d",
                   want.remaining_size, got.remaining_size);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel      = 1'b0;
   logic         penable   = 1'b0;
   logic         pwrite    = 1'b0;
   logic [2:0]   paddr     = '0;
   logic [31:0]  pwdata    = '0;
   logic [31:0]  prdata;
   logic         pready;

   hole_table_predictor table_model;
   bit                  steady = 1'b0;   // no idling on either side while set
   int                  cycle_count = 0;

   hole_fit_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stall before each word, check on acceptance
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 14);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         table_model.compare_grant(rsp_word);
      end
   end

   function automatic req_word_type make_word(logic op, logic [IDX_W-1:0] idx,
                                              logic [REQ_W-1:0] lsz, logic [REQ_W-1:0] req);
      req_word_type w;
      w.op           = op;
      w.hole_index   = idx;
      w.load_size    = lsz;
      w.request_size = req;
      return w;
   endfunction

   // Size limited to the low 'bits' bits, so holes and requests meet often
   function automatic logic [REQ_W-1:0] scaled_size(int bits);
      logic [31:0] mask;
      mask = (32'h1 << bits) - 1;
      return REQ_W'($urandom & mask);
   endfunction

   // Send one request word after a random gap, note it when accepted
   task automatic send_word(req_word_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      table_model.predict_word(w);
   endtask

   // Wait for all grants, then let any load or search in flight finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (table_model.expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      table_model.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly load-then-allocate sequences at one size scale, some noise words
   task automatic run_phase(int words);
      int sent;
      int bits;
      int n;
      int k;
      logic [REQ_W-1:0] req;
      sent = 0;
      while (sent < words) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 15) begin
            send_word(make_word(1'($urandom), IDX_W'($urandom), REQ_W'($urandom),
                                REQ_W'($urandom)));
            sent++;
         end else begin
            bits = $urandom_range(1, 16);
            n    = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               send_word(make_word(OP_LOAD, IDX_W'($urandom_range(0, 15)), scaled_size(bits),
                                   REQ_W'($urandom)));
               sent++;
            end
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               req = ($urandom_range(0, 9) == 0) ? '0 : scaled_size($urandom_range(1, bits));
               send_word(make_word(OP_ALLOC, IDX_W'($urandom), REQ_W'($urandom), req));
               sent++;
            end
         end
      end
   endtask

   initial begin
      int               p;
      logic [MODE_W-1:0] mode;
      int               count;
      table_model = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, full-size holes, alternating bit patterns
      steady = 1'b1;
      send_word(make_word(OP_ALLOC, '0, '0, 16'h0000));      // zero request fits empty hole
      send_word(make_word(OP_ALLOC, '1, '1, 16'h0001));      // nothing fits
      send_word(make_word(OP_LOAD, 4'd0, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_LOAD, 4'd15, 16'hFFFF, 16'h0000));
      send_word(make_word(OP_ALLOC, 4'd15, 16'h0000, 16'hFFFF));
      send_word(make_word(OP_ALLOC, 4'd0, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_ALLOC, 4'd0, 16'h0000, 16'hFFFF));
      send_word(make_word(OP_LOAD, 4'd5, 16'hAAAA, 16'h5555));
      send_word(make_word(OP_LOAD, 4'd10, 16'h5555, 16'hAAAA));
      send_word(make_word(OP_ALLOC, 4'd10, 16'h5555, 16'h5555));
      send_word(make_word(OP_ALLOC, 4'd5, 16'hAAAA, 16'h5556));
      send_word(make_word(OP_ALLOC, 4'd0, 16'h0000, 16'h5555));
      send_word(make_word(OP_ALLOC, 4'd0, 16'h0000, 16'h5555));
      send_word(make_word(OP_LOAD, 4'd3, 16'h0001, 16'h0000));
      send_word(make_word(OP_ALLOC, 4'd3, 16'h0000, 16'h0000));
      send_word(make_word(OP_ALLOC, 4'd3, 16'h0000, 16'h0001));
      steady = 1'b0;
      send_word(make_word(OP_ALLOC, 4'd3, 16'h0000, 16'h0001));
      settle();

      // Random phases, each under one register setting
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:  begin mode = FIT_BEST;  count = 16; end
            1:  begin mode = FIT_WORST; count = 16; end
            2:  begin mode = FIT_FIRST; count = 1;  end
            3:  begin mode = FIT_BEST;  count = 0;  end
            4:  begin mode = FIT_WORST; count = 31; end
            5:  begin mode = FIT_SPARE; count = 16; end
            6:  begin mode = FIT_BEST;  count = 2;  end
            7:  begin mode = FIT_FIRST; count = 17; end
            8:  begin mode = FIT_WORST; count = 5;  end
            11: begin mode = FIT_FIRST; count = 16; end
            default: begin
               mode  = MODE_W'($urandom_range(0, 3));
               count = $urandom_range(0, 31);
            end
         endcase
         csr_write(REG_FIT_MODE, 32'(mode));
         csr_write(REG_HOLE_COUNT, 32'(count));
         run_phase(PHASE_WORDS);
         settle();
      end

      $display("Covered %0d load words and %0d allocations (%0d granted, %0d refused)",
               table_model.loads_seen, table_model.grants_seen + table_model.refusals_seen,
               table_model.grants_seen, table_model.refusals_seen);
      $display("over %0d register settings in all four mode values, %0d cycles",
               PHASES + 1, cycle_count);
      if (table_model.mismatches == 0 && table_model.expected_grants.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/hfa_pkg.sv
design/hfa_cell.sv
design/hole_fit_allocator.sv
design/hfa_checker.sv
tb/hole_fit_allocator_tb.sv
